@@ rtl/core/ncs_pkg.sv @@
// Package for the nearest-center cosine search block.
// Holds shared widths and command codes. No dependencies.
package ncs_pkg;
	localparam int NumCentersDef = 600;
	localparam int CompWidthDef  = 16;
	localparam int SlotW         = 10;
	localparam logic CmdLoad  = 1'b0;
	localparam logic CmdQuery = 1'b1;
endpackage

@@ rtl/core/ncs_stream_if.sv @@
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing; the payload type is a parameter.
interface ncs_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/ncs_divider.sv @@
// Restoring divider, one quotient bit per cycle, for the cosine scaling.
// Uses ncs_pkg.
module ncs_divider import ncs_pkg::*; #(
	parameter int NumW = 64,
	parameter int DenW = 40
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NumW-1:0] num,
	input  logic [DenW-1:0] den,
	output logic            done,
	output logic [NumW-1:0] quo
);
	localparam int CntW = $clog2(NumW + 1);
	logic [NumW-1:0] quo_q;
	logic [DenW:0]   rem_q;
	logic [DenW-1:0] den_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic [DenW:0]   trial;
	logic [DenW:0]   shifted;

	assign shifted = {rem_q[DenW-1:0], quo_q[NumW-1]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(NumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[DenW]) begin
				rem_q <= trial;
				quo_q <= {quo_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[NumW-2:0], 1'b0};
			end
		end
	end
	assign quo = quo_q;
endmodule

@@ rtl/core/ncs_sqrt.sv @@
// Bit-pair integer square root, one result bit per cycle.
// Uses ncs_pkg.
module ncs_sqrt import ncs_pkg::*; #(
	parameter int InW = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [InW-1:0]     x,
	output logic               done,
	output logic [InW/2-1:0]   root
);
	localparam int RW   = InW / 2;
	localparam int CntW = $clog2(RW + 1);
	logic [InW-1:0]  x_q;
	logic [RW+1:0]   rem_q;
	logic [RW-1:0]   r_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic [RW+1:0]   cur;
	logic [RW+1:0]   trial;

	assign cur   = {rem_q[RW-1:0], x_q[InW-1:InW-2]};
	assign trial = cur - {r_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			rem_q <= '0;
			r_q   <= '0;
		end else if (busy_q) begin
			x_q <= {x_q[InW-3:0], 2'b00};
			if (!trial[RW+1]) begin
				rem_q <= trial;
				r_q   <= {r_q[RW-2:0], 1'b1};
			end else begin
				rem_q <= cur;
				r_q   <= {r_q[RW-2:0], 1'b0};
			end
		end
	end
	assign root = r_q;
endmodule

@@ rtl/core/nearest_center_cosine_search_top.sv @@
// Top level of the nearest-center cosine search: center memory, scan, norm and divide.
// Uses ncs_pkg, ncs_stream_if, ncs_sqrt and ncs_divider.
//
//  channel   | dir | payload
//  in_ch     | in  | cmd, slot, w_part, x_part, y_part, z_part
//  out_ch    | out | nearest_slot, cosine, zero_norm
//
// A load writes the addressed center slot. After acceptance, a query reads one memory
// word per center, drains the scan pipeline, then runs the square root and the
// bit-serial divider. A zero query skips the divide. arst_n clears control only;
// the center memory is undefined until written. A stalled result holds in the
// output register; the next item is taken once the result has left.
module nearest_center_cosine_search_top import ncs_pkg::*; #(
	parameter int NUM_CENTERS = NumCentersDef,
	parameter int COMP_WIDTH  = CompWidthDef
) (
	input logic clk,
	input logic arst_n,
	ncs_stream_if.sink   in_ch,
	ncs_stream_if.source out_ch
);
	localparam int CW   = COMP_WIDTH;
	localparam int PW   = 2 * CW;
	localparam int DW   = PW + 3;
	localparam int SW   = PW + 2;
	localparam int SQW  = 2 * ((SW + 16 + 1) / 2);
	localparam int NW   = SQW / 2;
	localparam int NUMW = DW + 10;

	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StScan = 3'd1;
	localparam logic [2:0] StMul  = 3'd2;
	localparam logic [2:0] StSqrt = 3'd3;
	localparam logic [2:0] StDiv  = 3'd4;

	logic [4*CW-1:0] mem [NUM_CENTERS];
	logic [4*CW-1:0] rd_s1;
	logic [2:0]      st_q;
	logic [SlotW-1:0] rd_idx_q, idx_s1, best_idx_q;
	logic            rd_v_s1, rd_v_s2;
	logic [SlotW-1:0] idx_s2;
	logic signed [CW-1:0] q_q [4];
	logic signed [PW-1:0] prod_s2 [4];
	logic signed [DW-1:0] best_q, dot_s3;
	logic [SW-1:0]   sumsq_q;
	logic [SlotW-1:0] idx_s3;
	logic            v_s3;
	logic            sq_start, sq_done, dv_start, dv_done;
	logic [NW-1:0]   root;
	logic [NUMW-1:0] quo;
	logic [SlotW-1:0] out_slot_q;
	logic [CW-1:0]   out_cos_q;
	logic            out_zero_q, out_v_q;
	logic            best_neg_q;
	logic            accept;
	logic [DW-1:0]   mag;
	logic [NUMW-1:0] num;
	logic [CW-1:0]   sat_cos;

	assign in_ch.ready = (st_q == StIdle) && !out_v_q;
	assign accept      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk) begin
		if (accept && in_ch.data.cmd == CmdLoad &&
		    {1'b0, in_ch.data.slot} < (SlotW+1)'(NUM_CENTERS))
			mem[in_ch.data.slot] <= {in_ch.data.w_part, in_ch.data.x_part,
			                         in_ch.data.y_part, in_ch.data.z_part};
		rd_s1  <= mem[rd_idx_q];
		idx_s1 <= rd_idx_q;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			q_q[0] <= in_ch.data.w_part;
			q_q[1] <= in_ch.data.x_part;
			q_q[2] <= in_ch.data.y_part;
			q_q[3] <= in_ch.data.z_part;
		end
		for (int k = 0; k < 4; k++)
			prod_s2[k] <= q_q[k] * $signed(rd_s1[(3-k)*CW +: CW]);
		idx_s2 <= idx_s1;
		dot_s3 <= DW'(prod_s2[0]) + DW'(prod_s2[1]) + DW'(prod_s2[2]) + DW'(prod_s2[3]);
		idx_s3 <= idx_s2;
		if (st_q == StMul)
			sumsq_q <= SW'(unsigned'(PW'(q_q[0] * q_q[0]))) +
			           SW'(unsigned'(PW'(q_q[1] * q_q[1]))) +
			           SW'(unsigned'(PW'(q_q[2] * q_q[2]))) +
			           SW'(unsigned'(PW'(q_q[3] * q_q[3])));
	end

	// The root stays in the square-root unit until the next query starts it.
	assign sq_start = (st_q == StMul) && !v_s3 && !rd_v_s2 && !rd_v_s1;
	assign mag      = best_q[DW-1] ? DW'(-best_q) : best_q;
	assign num      = NUMW'({mag, 9'd0}) + NUMW'(root);
	assign dv_start = sq_done && (root != '0);

	always_comb begin
		if (best_neg_q)
			sat_cos = (quo > NUMW'(1 << (CW-1))) ? CW'(1 << (CW-1)) : CW'(-quo);
		else
			sat_cos = (quo > NUMW'((1 << (CW-1)) - 1)) ? CW'((1 << (CW-1)) - 1) : CW'(quo);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= StIdle;
			rd_idx_q <= '0;
			rd_v_s1  <= 1'b0;
			rd_v_s2  <= 1'b0;
			v_s3     <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			rd_v_s1 <= (st_q == StScan);
			rd_v_s2 <= rd_v_s1;
			v_s3    <= rd_v_s2;
			if (out_ch.valid && out_ch.ready) out_v_q <= 1'b0;
			case (st_q)
				StIdle: begin
					if (accept && in_ch.data.cmd == CmdQuery) begin
						st_q     <= StScan;
						rd_idx_q <= '0;
					end
				end
				StScan: begin
					if (rd_idx_q == SlotW'(NUM_CENTERS - 1)) st_q <= StMul;
					else rd_idx_q <= rd_idx_q + 1'b1;
				end
				StMul: if (sq_start) st_q <= StSqrt;
				StSqrt: begin
					if (sq_done) begin
						if (root == '0) begin
							st_q    <= StIdle;
							out_v_q <= 1'b1;
						end else st_q <= StDiv;
					end
				end
				StDiv: begin
					if (dv_done) begin
						st_q    <= StIdle;
						out_v_q <= 1'b1;
					end
				end
				default: st_q <= StIdle;
			endcase
		end
	end

	// Best tracking also records the dot of center 0 for the no-positive case.
	always_ff @(posedge clk) begin
		if (accept) begin
			best_idx_q <= '0;
			best_q     <= '0;
			best_neg_q <= 1'b0;
		end else if (v_s3) begin
			if (idx_s3 == '0 && dot_s3 <= 0) begin
				best_q     <= dot_s3;
				best_neg_q <= dot_s3[DW-1];
			end else if (dot_s3 > 0 && (dot_s3 > best_q || best_q <= 0)) begin
				best_q     <= dot_s3;
				best_idx_q <= idx_s3;
				best_neg_q <= 1'b0;
			end
		end
		if (st_q == StSqrt && sq_done && root == '0) begin
			out_slot_q <= '0;
			out_cos_q  <= '0;
			out_zero_q <= 1'b1;
		end else if (dv_done) begin
			out_slot_q <= best_idx_q;
			out_cos_q  <= sat_cos;
			out_zero_q <= 1'b0;
		end
	end

	ncs_sqrt #(.InW(SQW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start),
		.x(SQW'({sumsq_q, 16'd0})),
		.done(sq_done), .root(root)
	);

	ncs_divider #(.NumW(NUMW), .DenW(NW + 1)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start),
		.num(num), .den({root, 1'b0}), .done(dv_done), .quo(quo)
	);

	assign out_ch.valid             = out_v_q;
	assign out_ch.data.nearest_slot = out_slot_q;
	assign out_ch.data.cosine       = out_cos_q;
	assign out_ch.data.zero_norm    = out_zero_q;
endmodule

@@ rtl/core/ncs_checker.sv @@
// Port-level checker for the nearest-center cosine search, bound to the top level.
// Uses ncs_pkg.
module ncs_checker import ncs_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             in_cmd,
	input logic             out_valid,
	input logic             out_ready,
	input logic [SlotW-1:0] out_slot,
	input logic             out_zero
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_slot)) else $error("result dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_cmd == CmdQuery |=> !in_ready) else $error("query overlap");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_zero |-> out_slot == '0) else $error("zero query slot");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accept while result waits");
endmodule

bind nearest_center_cosine_search_top ncs_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_cmd(in_ch.data.cmd),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_slot(out_ch.data.nearest_slot), .out_zero(out_ch.data.zero_norm)
);
